/* src/lsbx_pkg.sv */
// Shared types and constants for the BMP LSB message extractor.
package lsbx_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_SKIP    = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_MESSAGE = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FORMAT   = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;
    localparam logic [1:0] ST_EARLY    = 2'd3;

    localparam logic KIND_MESSAGE = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [7:0]  SIG_B        = 8'h42;
    localparam logic [7:0]  SIG_M        = 8'h4D;
    localparam logic [15:0] BPP_24       = 16'd24;
    localparam logic [31:0] POS_OFF_0    = 32'd10;
    localparam logic [31:0] POS_OFF_1    = 32'd11;
    localparam logic [31:0] POS_OFF_2    = 32'd12;
    localparam logic [31:0] POS_OFF_3    = 32'd13;
    localparam logic [31:0] POS_DEPTH_LO = 32'd28;
    localparam logic [31:0] POS_DEPTH_HI = 32'd29;
    localparam logic [31:0] POS_COMP_LO  = 32'd30;
    localparam logic [31:0] HEADER_LAST  = 32'd33;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] message_byte;
        logic [1:0] status;
        logic       end_of_message;
    } t_result;

endpackage

/* src/lsbx_in_reg.sv */
// Input register stage holding one file word ahead of the parser.
module lsbx_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lsbx_pkg::t_item i_item,
    input  logic           i_down_free,
    output logic           o_valid,
    output lsbx_pkg::t_item o_item
);

    logic            r_valid;
    lsbx_pkg::t_item r_item;
    logic            w_consume;

    assign w_consume = r_valid && i_down_free;
    assign o_ready   = !r_valid || w_consume;
    assign o_valid   = r_valid;
    assign o_item    = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (w_consume) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

/* src/lsbx_parser.sv */
// Header checks, LSB gathering and message sequencing, one word per step.
module lsbx_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_file_size_we,
    input  logic [31:0]       i_file_size_bytes,
    input  logic              i_step,
    input  lsbx_pkg::t_item   i_item,
    output logic              o_res_valid,
    output lsbx_pkg::t_result o_res
);

    logic [31:0]      r_file_size;
    logic [31:0]      r_pos,      n_pos;
    logic [31:0]      r_off,      n_off;
    logic [15:0]      r_depth,    n_depth;
    logic             r_comp,     n_comp;
    logic             r_sig,      n_sig;
    logic [7:0]       r_gather,   n_gather;
    logic [2:0]       r_bit_cnt,  n_bit_cnt;
    logic [31:0]      r_len,      n_len;
    logic [31:0]      r_rem,      n_rem;
    lsbx_pkg::t_phase r_phase,    n_phase;

    logic [7:0]  w_b;
    logic [7:0]  w_gathered;
    logic        w_last_bit;
    logic [4:0]  w_rel;
    logic [1:0]  w_k;
    logic [31:0] w_avail;
    logic [35:0] w_need;
    logic        w_hdr_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= '0;
        end else if (i_file_size_we) begin
            r_file_size <= i_file_size_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_off     <= '0;
            r_depth   <= '0;
            r_comp    <= 1'b0;
            r_sig     <= 1'b0;
            r_gather  <= '0;
            r_bit_cnt <= '0;
            r_len     <= '0;
            r_rem     <= '0;
            r_phase   <= lsbx_pkg::PH_HEADER;
        end else begin
            r_pos     <= n_pos;
            r_off     <= n_off;
            r_depth   <= n_depth;
            r_comp    <= n_comp;
            r_sig     <= n_sig;
            r_gather  <= n_gather;
            r_bit_cnt <= n_bit_cnt;
            r_len     <= n_len;
            r_rem     <= n_rem;
            r_phase   <= n_phase;
        end
    end

    assign w_b        = i_item.file_byte;
    assign w_gathered = {r_gather[6:0], w_b[0]};
    assign w_last_bit = (r_bit_cnt == 3'd7);
    // only the low bits of the distance into the pixel data pick the length byte
    assign w_rel      = r_pos[4:0] - r_off[4:0];
    assign w_k        = w_rel[4:3];

    always_comb begin
        n_pos       = r_pos;
        n_off       = r_off;
        n_depth     = r_depth;
        n_comp      = r_comp;
        n_sig       = r_sig;
        n_gather    = r_gather;
        n_bit_cnt   = r_bit_cnt;
        n_len       = r_len;
        n_rem       = r_rem;
        n_phase     = r_phase;
        o_res_valid = 1'b0;
        o_res       = '0;
        w_avail     = '0;
        w_need      = '0;
        w_hdr_ok    = 1'b0;

        if (i_step) begin
            unique case (r_phase)
                lsbx_pkg::PH_HEADER: begin
                    if (r_pos == 32'd0) begin
                        n_sig = (w_b == lsbx_pkg::SIG_B);
                    end else if (r_pos == 32'd1) begin
                        n_sig = r_sig && (w_b == lsbx_pkg::SIG_M);
                    end else if (r_pos == lsbx_pkg::POS_OFF_0) begin
                        n_off = r_off | {24'd0, w_b};
                    end else if (r_pos == lsbx_pkg::POS_OFF_1) begin
                        n_off = r_off | {16'd0, w_b, 8'd0};
                    end else if (r_pos == lsbx_pkg::POS_OFF_2) begin
                        n_off = r_off | {8'd0, w_b, 16'd0};
                    end else if (r_pos == lsbx_pkg::POS_OFF_3) begin
                        n_off = r_off | {w_b, 24'd0};
                    end else if (r_pos == lsbx_pkg::POS_DEPTH_LO) begin
                        n_depth = r_depth | {8'd0, w_b};
                    end else if (r_pos == lsbx_pkg::POS_DEPTH_HI) begin
                        n_depth = r_depth | {w_b, 8'd0};
                    end else if (r_pos >= lsbx_pkg::POS_COMP_LO &&
                                 r_pos <= lsbx_pkg::HEADER_LAST && w_b != 8'd0) begin
                        n_comp = 1'b1;
                    end
                    if (r_pos == lsbx_pkg::HEADER_LAST) begin
                        w_hdr_ok = r_sig && (n_depth == lsbx_pkg::BPP_24) && !n_comp &&
                                   (r_off > lsbx_pkg::HEADER_LAST) && (r_off < r_file_size);
                        if (w_hdr_ok) begin
                            n_phase = lsbx_pkg::PH_SKIP;
                        end else begin
                            o_res_valid          = 1'b1;
                            o_res.kind           = lsbx_pkg::KIND_STATUS;
                            o_res.status         = lsbx_pkg::ST_FORMAT;
                            o_res.end_of_message = 1'b1;
                            n_phase              = lsbx_pkg::PH_DONE;
                        end
                    end
                end
                lsbx_pkg::PH_SKIP: begin
                    if (r_pos == r_off) begin
                        n_phase = lsbx_pkg::PH_LENGTH;
                    end
                end
                default: begin
                end
            endcase

            if (n_phase == lsbx_pkg::PH_LENGTH) begin
                n_gather  = w_gathered;
                n_bit_cnt = w_last_bit ? 3'd0 : r_bit_cnt + 3'd1;
                if (w_last_bit) begin
                    n_gather = '0;
                    n_len    = r_len | (32'(w_gathered) << {w_k, 3'b000});
                    if (w_k == 2'd3) begin
                        w_avail = (r_file_size >= r_off) ? r_file_size - r_off : 32'd0;
                        w_need  = {33'(n_len) + 33'd4, 2'b00, 1'b0};
                        if (36'(w_avail) < w_need) begin
                            o_res_valid          = 1'b1;
                            o_res.kind           = lsbx_pkg::KIND_STATUS;
                            o_res.status         = lsbx_pkg::ST_CAPACITY;
                            o_res.end_of_message = 1'b1;
                            n_phase              = lsbx_pkg::PH_DONE;
                        end else if (n_len == 32'd0) begin
                            o_res_valid          = 1'b1;
                            o_res.kind           = lsbx_pkg::KIND_STATUS;
                            o_res.status         = lsbx_pkg::ST_OK;
                            o_res.end_of_message = 1'b1;
                            n_phase              = lsbx_pkg::PH_DONE;
                        end else begin
                            n_rem   = n_len;
                            n_phase = lsbx_pkg::PH_MESSAGE;
                        end
                    end
                end
            end else if (n_phase == lsbx_pkg::PH_MESSAGE) begin
                n_gather  = w_gathered;
                n_bit_cnt = w_last_bit ? 3'd0 : r_bit_cnt + 3'd1;
                if (w_last_bit) begin
                    n_gather           = '0;
                    n_rem              = r_rem - 32'd1;
                    o_res_valid        = 1'b1;
                    o_res.kind         = lsbx_pkg::KIND_MESSAGE;
                    o_res.message_byte = w_gathered;
                    if (n_rem == 32'd0) begin
                        o_res.end_of_message = 1'b1;
                        n_phase              = lsbx_pkg::PH_DONE;
                    end else if (i_item.end_of_file) begin
                        o_res.status         = lsbx_pkg::ST_EARLY;
                        o_res.end_of_message = 1'b1;
                    end
                end
            end

            // file ends with no word due: report why
            if (i_item.end_of_file && !o_res_valid &&
                (n_phase == lsbx_pkg::PH_HEADER || n_phase == lsbx_pkg::PH_SKIP ||
                 n_phase == lsbx_pkg::PH_LENGTH || n_phase == lsbx_pkg::PH_MESSAGE)) begin
                o_res_valid          = 1'b1;
                o_res.kind           = lsbx_pkg::KIND_STATUS;
                o_res.status         = (n_phase == lsbx_pkg::PH_HEADER) ?
                                       lsbx_pkg::ST_FORMAT : lsbx_pkg::ST_EARLY;
                o_res.end_of_message = 1'b1;
            end

            if (i_item.end_of_file) begin
                n_pos     = '0;
                n_off     = '0;
                n_depth   = '0;
                n_comp    = 1'b0;
                n_sig     = 1'b0;
                n_gather  = '0;
                n_bit_cnt = '0;
                n_len     = '0;
                n_rem     = '0;
                n_phase   = lsbx_pkg::PH_HEADER;
            end else begin
                n_pos = r_pos + 32'd1;
            end
        end
    end

endmodule

/* src/lsbx_out_reg.sv */
// Result register holding one word until the consumer takes it.
module lsbx_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lsbx_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output lsbx_pkg::t_result o_res
);

    logic              r_valid;
    lsbx_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* src/lsb_stego_bmp_extractor_core.sv */
// Top level of the BMP LSB message extractor.
// Takes one file word per cycle and gives at most one result word per file word; a word
// passes the input register and the parser into the result register. Throughput is one word
// a cycle, as the header, gather and count update in the parser stage is combinational;
// the input side stalls only while the result register is full and not being taken.
// Write the file size before the first word of a file; after a word with the end-of-file
// mark the block is ready for the next file at once.
module lsb_stego_bmp_extractor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_file_size_we,
    input  logic [31:0] i_file_size_bytes,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_message_byte,
    output logic [1:0]  o_status,
    output logic        o_end_of_message
);

    lsbx_pkg::t_item   w_in_item;
    lsbx_pkg::t_item   w_stage_item;
    lsbx_pkg::t_result w_res;
    lsbx_pkg::t_result w_out_res;
    logic              w_stage_valid;
    logic              w_out_free;
    logic              w_step;
    logic              w_res_valid;

    assign w_in_item.file_byte   = i_file_byte;
    assign w_in_item.end_of_file = i_end_of_file;
    assign w_step                = w_stage_valid && w_out_free;

    lsbx_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (w_in_item),
        .i_down_free (w_out_free),
        .o_valid     (w_stage_valid),
        .o_item      (w_stage_item)
    );

    lsbx_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_file_size_we    (i_file_size_we),
        .i_file_size_bytes (i_file_size_bytes),
        .i_step            (w_step),
        .i_item            (w_stage_item),
        .o_res_valid       (w_res_valid),
        .o_res             (w_res)
    );

    lsbx_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step && w_res_valid),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (w_out_res)
    );

    assign o_kind           = w_out_res.kind;
    assign o_message_byte   = w_out_res.message_byte;
    assign o_status         = w_out_res.status;
    assign o_end_of_message = w_out_res.end_of_message;

endmodule

/* src/lsbx_checker.sv */
// Port-level checks on the extractor, bound to the top level.
module lsbx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_kind,
    input logic [7:0]  o_message_byte,
    input logic [1:0]  o_status,
    input logic        o_end_of_message
);

    // result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) &&
        $stable(o_message_byte) && $stable(o_status) && $stable(o_end_of_message))
        else $error("result word changed while stalled");

    // reset leaves the output empty and the input open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("bad state after reset");

    a_status_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == lsbx_pkg::KIND_STATUS ||
                        o_status != lsbx_pkg::ST_OK) |-> o_end_of_message)
        else $error("status word without end of message");

    a_status_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == lsbx_pkg::KIND_STATUS |-> o_message_byte == 8'd0)
        else $error("status word carries a byte");

    a_capacity_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == lsbx_pkg::ST_CAPACITY ||
                        o_status == lsbx_pkg::ST_FORMAT) |-> o_kind == lsbx_pkg::KIND_STATUS)
        else $error("header or capacity error on a message word");

endmodule

bind lsb_stego_bmp_extractor_core lsbx_checker u_lsbx_checker (.*);
